/* src/gn2d_pkg.sv */
package gn2d_pkg;

    typedef logic signed [21:0] t_val;

    localparam logic [31:0] PRIME_X  = 32'h1dde90c9;
    localparam logic [31:0] PRIME_Y  = 32'h43c42e4d;
    localparam logic [31:0] HASH_MUL = 32'h27d4eb2d;

    localparam t_val ONE_Q16   = 22'sd65536;
    localparam t_val G_BIG_Q16 = 22'sd158218;
    localparam t_val FADE_C15  = 22'sd983040;
    localparam t_val FADE_C10  = 22'sd655360;

    localparam logic signed [24:0] SCALE_Q24 = 25'sd9715803;
    localparam logic signed [46:0] ROUND_Q25 = 47'sd16777216;

    localparam logic signed [21:0] SAT_MAX = 22'sd32767;
    localparam logic signed [21:0] SAT_MIN = -22'sd32768;

    // gradient set: (+-(1+sqrt2), +-1) then (+-1, +-(1+sqrt2))
    function automatic t_val grad_x(input logic [2:0] k);
        t_val mag;
        mag = k[2] ? ONE_Q16 : G_BIG_Q16;
        return k[0] ? -mag : mag;
    endfunction

    function automatic t_val grad_y(input logic [2:0] k);
        t_val mag;
        mag = k[2] ? G_BIG_Q16 : ONE_Q16;
        return k[1] ? -mag : mag;
    endfunction

endpackage

/* src/gradient_noise_2d.sv */
// Throughput: one word per cycle unless a stalled output has filled every stage; the
// fade chain, hash, dot and blend multipliers spread over the first seven of eight
// register stages, the last one saturating.
// Each stage advances on its own, so bubbles close up while the output stalls.
// Reset (synchronous, active low) empties the pipeline and sets the seed to 0.
module gradient_noise_2d #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic        [31:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_noise_value
);

    localparam int NumStages = 8;

    function automatic gn2d_pkg::t_val fade_mul(input gn2d_pkg::t_val a,
                                                input gn2d_pkg::t_val t);
        logic signed [43:0] p;
        p = 44'(a) * 44'(t);
        return gn2d_pkg::t_val'(p >>> 16);
    endfunction

    function automatic gn2d_pkg::t_val dot(input logic [2:0] k,
                                           input gn2d_pkg::t_val dx,
                                           input gn2d_pkg::t_val dy);
        logic signed [44:0] s;
        s = 45'(gn2d_pkg::grad_x(k)) * 45'(dx) + 45'(gn2d_pkg::grad_y(k)) * 45'(dy);
        return gn2d_pkg::t_val'(s >>> 16);
    endfunction

    function automatic gn2d_pkg::t_val lerp(input gn2d_pkg::t_val f,
                                            input gn2d_pkg::t_val a,
                                            input gn2d_pkg::t_val b);
        logic signed [22:0] diff;
        logic signed [45:0] p;
        diff = 23'(b) - 23'(a);
        p = 46'(diff) * 46'(f);
        return a + gn2d_pkg::t_val'(p >>> 16);
    endfunction

    logic [31:0]          r_seed;
    logic [NumStages-1:0] r_vld;
    logic [NumStages-1:0] w_en;

    logic [15:0] w_ux, w_uy;
    logic [31:0] w_cx, w_cy;

    if (FRAC_BITS >= 16) begin : g_frac_hi
        assign w_ux = i_x_coord[FRAC_BITS-1 -: 16];
        assign w_uy = i_y_coord[FRAC_BITS-1 -: 16];
    end else begin : g_frac_lo
        assign w_ux = {i_x_coord[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
        assign w_uy = {i_y_coord[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
    end

    assign w_cx = i_x_coord >>> FRAC_BITS;
    assign w_cy = i_y_coord >>> FRAC_BITS;

    always_comb begin
        w_en[NumStages-1] = !r_vld[NumStages-1] || i_out_ready;
        for (int s = NumStages - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NumStages-1];

    // stage 1: lattice primes, first fade term
    logic [31:0]     r1_x0, r1_y0;
    logic [15:0]     r1_ux, r1_uy;
    gn2d_pkg::t_val  r1_fx, r1_fy;
    // stage 2: corner gradient codes, fade
    logic [2:0]      r2_k [4];
    logic [15:0]     r2_ux, r2_uy;
    gn2d_pkg::t_val  r2_fx, r2_fy;
    // stage 3: dot products, fade
    gn2d_pkg::t_val  r3_d [4];
    logic [15:0]     r3_ux, r3_uy;
    gn2d_pkg::t_val  r3_fx, r3_fy;
    // stage 4: fade done
    gn2d_pkg::t_val  r4_d [4];
    gn2d_pkg::t_val  r4_fx, r4_fy;
    // stage 5, 6, 7: blends and scale
    gn2d_pkg::t_val  r5_l0, r5_l1, r5_fy;
    gn2d_pkg::t_val  r6_r;
    logic signed [46:0] r7_prod;
    logic signed [15:0] r_noise;

    gn2d_pkg::t_val     n1_fx, n1_fy, n1_tx, n1_ty;
    logic [31:0]        n2_x1, n2_y1;
    logic [2:0]         n2_k [4];
    gn2d_pkg::t_val     n3_dx0, n3_dx1, n3_dy0, n3_dy1;
    logic signed [21:0] n8_q;

    always_comb begin
        n1_tx = gn2d_pkg::t_val'({6'b0, w_ux});
        n1_ty = gn2d_pkg::t_val'({6'b0, w_uy});
        n1_fx = fade_mul((n1_tx <<< 2) + (n1_tx <<< 1) - gn2d_pkg::FADE_C15, n1_tx)
                + gn2d_pkg::FADE_C10;
        n1_fy = fade_mul((n1_ty <<< 2) + (n1_ty <<< 1) - gn2d_pkg::FADE_C15, n1_ty)
                + gn2d_pkg::FADE_C10;
    end

    always_comb begin
        logic [31:0] h [4];
        n2_x1 = r1_x0 + gn2d_pkg::PRIME_X;
        n2_y1 = r1_y0 + gn2d_pkg::PRIME_Y;
        h[0] = (r_seed ^ r1_x0 ^ r1_y0) * gn2d_pkg::HASH_MUL;
        h[1] = (r_seed ^ n2_x1 ^ r1_y0) * gn2d_pkg::HASH_MUL;
        h[2] = (r_seed ^ r1_x0 ^ n2_y1) * gn2d_pkg::HASH_MUL;
        h[3] = (r_seed ^ n2_x1 ^ n2_y1) * gn2d_pkg::HASH_MUL;
        for (int c = 0; c < 4; c++) begin
            n2_k[c] = h[c][2:0] ^ h[c][17:15];
        end
    end

    always_comb begin
        n3_dx0 = gn2d_pkg::t_val'({6'b0, r2_ux});
        n3_dy0 = gn2d_pkg::t_val'({6'b0, r2_uy});
        n3_dx1 = n3_dx0 - gn2d_pkg::ONE_Q16;
        n3_dy1 = n3_dy0 - gn2d_pkg::ONE_Q16;
    end

    assign n8_q = 22'((r7_prod + gn2d_pkg::ROUND_Q25) >>> 25);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_vld  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
            end
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int s = 1; s < NumStages; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_x0 <= w_cx * gn2d_pkg::PRIME_X;
            r1_y0 <= w_cy * gn2d_pkg::PRIME_Y;
            r1_ux <= w_ux;
            r1_uy <= w_uy;
            r1_fx <= n1_fx;
            r1_fy <= n1_fy;
        end
        if (w_en[1]) begin
            r2_k  <= n2_k;
            r2_ux <= r1_ux;
            r2_uy <= r1_uy;
            r2_fx <= fade_mul(r1_fx, gn2d_pkg::t_val'({6'b0, r1_ux}));
            r2_fy <= fade_mul(r1_fy, gn2d_pkg::t_val'({6'b0, r1_uy}));
        end
        if (w_en[2]) begin
            r3_d[0] <= dot(r2_k[0], n3_dx0, n3_dy0);
            r3_d[1] <= dot(r2_k[1], n3_dx1, n3_dy0);
            r3_d[2] <= dot(r2_k[2], n3_dx0, n3_dy1);
            r3_d[3] <= dot(r2_k[3], n3_dx1, n3_dy1);
            r3_ux   <= r2_ux;
            r3_uy   <= r2_uy;
            r3_fx   <= fade_mul(r2_fx, n3_dx0);
            r3_fy   <= fade_mul(r2_fy, n3_dy0);
        end
        if (w_en[3]) begin
            r4_d  <= r3_d;
            r4_fx <= fade_mul(r3_fx, gn2d_pkg::t_val'({6'b0, r3_ux}));
            r4_fy <= fade_mul(r3_fy, gn2d_pkg::t_val'({6'b0, r3_uy}));
        end
        if (w_en[4]) begin
            r5_l0 <= lerp(r4_fx, r4_d[0], r4_d[1]);
            r5_l1 <= lerp(r4_fx, r4_d[2], r4_d[3]);
            r5_fy <= r4_fy;
        end
        if (w_en[5]) begin
            r6_r <= lerp(r5_fy, r5_l0, r5_l1);
        end
        if (w_en[6]) begin
            r7_prod <= 47'(r6_r) * 47'(gn2d_pkg::SCALE_Q24);
        end
        if (w_en[7]) begin
            priority if (n8_q > gn2d_pkg::SAT_MAX) begin
                r_noise <= 16'(gn2d_pkg::SAT_MAX);
            end else if (n8_q < gn2d_pkg::SAT_MIN) begin
                r_noise <= 16'(gn2d_pkg::SAT_MIN);
            end else begin
                r_noise <= 16'(n8_q);
            end
        end
    end

    assign o_noise_value = r_noise;

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !i_out_ready |-> !o_in_ready)
        else $error("input taken with a full, stalled pipeline");

    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_vld) |-> o_in_ready)
        else $error("input refused while a stage is empty");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted word lost at entry");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> o_out_valid == $past(r_vld[NumStages-2]))
        else $error("output stage not refilled from the stage before");

endmodule

/* tb/gradient_noise_2d_tb.sv */
`timescale 1ns / 1ps

module gradient_noise_2d_tb;

    localparam int LATENCY    = 8;
    localparam int IDLE_LIMIT = 400;
    localparam int PHASES     = 5;
    localparam int PHASE_LEN  = 260;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic        [31:0] i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_x_coord = '0;
    logic signed [31:0] i_y_coord = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_noise_value;

    logic signed [15:0] noise_expected[$];
    logic        [31:0] seed_shadow = '0;
    int                 err_count = 0;
    int                 words_in = 0;
    int                 words_out = 0;
    int                 seeds_used = 1;
    int                 burst_left = 0;
    bit                 quiet = 1'b0;
    int                 idle_cycles = 0;
    int                 rx_hold = 0;
    int unsigned        cyc = 0;

    gradient_noise_2d uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_noise_value(o_noise_value)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [31:0] lattice_hash(input logic [31:0] seed, xp, yp);
        logic [31:0] h;
        h = (seed ^ xp ^ yp) * gn2d_pkg::HASH_MUL;
        return h ^ (h >> 15);
    endfunction

    function automatic longint corner_dot(input logic [31:0] h, input longint dx, dy);
        longint big;
        longint one;
        longint gx;
        longint gy;
        big = longint'(gn2d_pkg::G_BIG_Q16);
        one = longint'(gn2d_pkg::ONE_Q16);
        case (h[2:0])
            3'd0: begin gx = big;  gy = one;  end
            3'd1: begin gx = -big; gy = one;  end
            3'd2: begin gx = big;  gy = -one; end
            3'd3: begin gx = -big; gy = -one; end
            3'd4: begin gx = one;  gy = big;  end
            3'd5: begin gx = -one; gy = big;  end
            3'd6: begin gx = one;  gy = -big; end
            default: begin gx = -one; gy = -big; end
        endcase
        return (gx * dx + gy * dy) >>> 16;
    endfunction

    function automatic longint quintic(input longint t);
        longint a;
        a = 6 * t - 15 * 65536;
        a = ((a * t) >>> 16) + 10 * 65536;
        a = (a * t) >>> 16;
        a = (a * t) >>> 16;
        a = (a * t) >>> 16;
        return a;
    endfunction

    function automatic longint mix(input longint f, a, b);
        return a + (((b - a) * f) >>> 16);
    endfunction

    function automatic logic signed [15:0] noise_of(input logic [31:0] x, y, seed);
        logic [31:0] x0, x1, y0, y1;
        longint ux, uy, fx, fy, r, q;
        longint d00, d10, d01, d11;
        ux = longint'(x[15:0]);
        uy = longint'(y[15:0]);
        x0 = {{16{x[31]}}, x[31:16]} * gn2d_pkg::PRIME_X;
        y0 = {{16{y[31]}}, y[31:16]} * gn2d_pkg::PRIME_Y;
        x1 = x0 + gn2d_pkg::PRIME_X;
        y1 = y0 + gn2d_pkg::PRIME_Y;
        fx = quintic(ux);
        fy = quintic(uy);
        d00 = corner_dot(lattice_hash(seed, x0, y0), ux, uy);
        d10 = corner_dot(lattice_hash(seed, x1, y0), ux - 65536, uy);
        d01 = corner_dot(lattice_hash(seed, x0, y1), ux, uy - 65536);
        d11 = corner_dot(lattice_hash(seed, x1, y1), ux - 65536, uy - 65536);
        r = mix(fy, mix(fx, d00, d10), mix(fx, d01, d11));
        q = (r * longint'(gn2d_pkg::SCALE_Q24) + (longint'(1) <<< 24)) >>> 25;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic logic [31:0] rand_coord();
        logic [15:0] lat_idx;
        logic [15:0] frac;
        lat_idx = 16'($urandom);
        frac = 16'($urandom);
        case ($urandom_range(0, 5))
            1: lat_idx = 16'($urandom_range(0, 15)) - 16'd8;
            2: case ($urandom_range(0, 3))
                0: frac = 16'h0000;
                1: frac = 16'hffff;
                2: frac = 16'h8000;
                default: frac = 16'h0001;
            endcase
            3: case ($urandom_range(0, 3))
                0: lat_idx = 16'h7fff;
                1: lat_idx = 16'h8000;
                2: lat_idx = 16'hffff;
                default: lat_idx = 16'h0000;
            endcase
            default: ;
        endcase
        return {lat_idx, frac};
    endfunction

    // receiver: stretches of random stalls, with always-ready spans
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            if (cyc[10:9] == 2'd0)
                i_out_ready <= 1'b1;
            else
                i_out_ready <= ($urandom_range(0, 3) != 0);
            rx_hold <= $urandom_range(0, 12);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_out++;
            if (noise_expected.size() == 0) begin
                $display("%0t unexpected word: expected none actual %0d", $time,
                         o_noise_value);
                err_count++;
            end else begin
                logic signed [15:0] want;
                want = noise_expected.pop_front();
                if (o_noise_value !== want) begin
                    $display("%0t noise mismatch: expected %0d actual %0d", $time,
                             want, o_noise_value);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_coord(input logic [31:0] x, y);
        int gap;
        if (burst_left == 0) begin
            gap = quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid <= 1'b1;
        i_x_coord  <= x;
        i_y_coord  <= y;
        do @(posedge i_clk); while (!o_in_ready);
        noise_expected.push_back(noise_of(x, y, seed_shadow));
        words_in++;
        burst_left--;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (noise_expected.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic set_seed(input logic [31:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        seed_shadow = v;
        seeds_used++;
    endtask

    task automatic peak_search(input bit want_max, output logic [31:0] bx, by);
        logic [31:0] x, y;
        logic signed [15:0] v, best;
        best = want_max ? -16'sd32768 : 16'sd32767;
        bx = '0;
        by = '0;
        for (int i = 0; i < 3000; i++) begin
            x = $urandom;
            y = $urandom;
            v = noise_of(x, y, seed_shadow);
            if (want_max ? (v > best) : (v < best)) begin
                best = v;
                bx = x;
                by = y;
            end
        end
    endtask

    logic [31:0] corner_x[12] = '{32'h00000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                  32'h80000000, 32'h0000ffff, 32'hffff0000, 32'h00008000,
                                  32'hffff8000, 32'h00010000, 32'h0000ffff, 32'hffffffff};
    logic [31:0] corner_y[12] = '{32'h00000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                                  32'h7fffffff, 32'hffff0000, 32'h0000ffff, 32'h00008000,
                                  32'h00018000, 32'hffffffff, 32'h0000ffff, 32'hffffffff};

    task automatic test_corners();
        for (int i = 0; i < 12; i++)
            push_coord(corner_x[i], corner_y[i]);
    endtask

    task automatic test_seed_ends();
        set_seed(32'hffffffff);
        for (int i = 0; i < 6; i++)
            push_coord(corner_x[i], corner_y[i]);
    endtask

    // hunt for the largest and smallest noise words of a random seed
    task automatic test_peaks();
        logic [31:0] x, y;
        set_seed($urandom);
        peak_search(1'b1, x, y);
        push_coord(x, y);
        peak_search(1'b0, x, y);
        push_coord(x, y);
    endtask

    task automatic test_random();
        logic [31:0] seeds[PHASES];
        seeds = '{32'h0, 32'h0, 32'hffffffff, 32'h80000000, 32'h0};
        seeds[0] = $urandom;
        seeds[4] = $urandom;
        for (int p = 0; p < PHASES; p++) begin
            set_seed(seeds[p]);
            quiet = (p == 2);
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (p == 1 && i == PHASE_LEN / 2)
                    drain();
                push_coord(rand_coord(), rand_coord());
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_seed_ends();
        test_peaks();
        test_random();
        drain();
        $display("Covered %0d coordinate words and %0d noise words over %0d seed settings,",
                 words_in, words_out, seeds_used);
        $display("lattice and fraction extremes, peak hunts, stalls and a full drain.");
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d errors", err_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
